// ===== src/tdpt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types and constants for the trial division primality tester.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    // First divisor of the 6k-1 / 6k+1 sequence and its square
    localparam int DIV_FIRST    = 5;
    localparam int SQ_FIRST     = 25;
    // Step between pairs, gap inside a pair
    localparam int DIV_STEP     = 6;
    localparam int DIV_PAIR_GAP = 2;
    // (i+6)^2 - i^2 = 12*i + 36
    localparam int SQ_STEP_ADD  = 36;
    // Small divisors screened before the pair loop
    localparam int DIV_TWO      = 2;
    localparam int DIV_THREE    = 3;
    localparam int ONE          = 1;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_NEXT   = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_FINISH = 4'b1000
    } t_state;

    // Which divisor is under test
    typedef enum logic [1:0] {
        PH_TWO   = 2'd0,
        PH_THREE = 2'd1,
        PH_LOW   = 2'd2,
        PH_HIGH  = 2'd3
    } t_phase;

    // Status from the remainder unit to the sequencer
    typedef struct packed {
        logic done;   // one-cycle pulse, remainder valid
        logic zero;   // remainder is zero
    } t_mod_status;

endpackage
`default_nettype wire

// ===== src/tdpt_mod_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tdpt_mod_unit
// Restoring remainder unit: one quotient bit per cycle, DATA_WIDTH bits
// per operation, reports whether the remainder is zero.
// ----------------------------------------------------------------------------
module tdpt_mod_unit #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_start,
    input  wire  [DATA_WIDTH-1:0]   i_dividend,
    input  wire  [DATA_WIDTH-1:0]   i_divisor,
    output tdpt_pkg::t_mod_status   o_status
);

    localparam int CW = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [DATA_WIDTH-1:0] r_shift, n_shift;
    logic [DATA_WIDTH-1:0] r_div, n_div;
    logic [DATA_WIDTH-1:0] r_rem, n_rem;
    logic [DATA_WIDTH:0]   w_trial;
    logic [DATA_WIDTH:0]   w_diff;

    assign w_trial = {r_rem, r_shift[DATA_WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_div   = r_div;
        n_rem   = r_rem;
        if (i_start && !r_busy) begin
            n_busy  = 1'b1;
            n_cnt   = CW'(DATA_WIDTH - 1);
            n_shift = i_dividend;
            n_div   = i_divisor;
            n_rem   = '0;
        end else if (r_busy) begin
            // keep the difference when the trial value covers the divisor
            if (!w_diff[DATA_WIDTH]) begin
                n_rem = w_diff[DATA_WIDTH-1:0];
            end else begin
                n_rem = w_trial[DATA_WIDTH-1:0];
            end
            n_shift = r_shift << 1;
            n_cnt   = r_cnt - CW'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
        r_div   <= n_div;
        r_rem   <= n_rem;
    end

    assign o_status.done = r_done;
    assign o_status.zero = (r_rem == '0);

endmodule
`default_nettype wire

// ===== src/trial_division_prime_test.sv =====
`default_nettype none
// Values below 4 and negative values go from accept to the finish state.
// Otherwise each trial divisor in turn uses the shared remainder unit:
// divisors 2 and 3 first, then pairs i, i+2 while i*i is at most the value.
// One item at a time: input stalls until the result is in the output register.
// Synchronous active-low reset clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality test by trial division with 6k-1 / 6k+1 divisor pairs, using one
// iterative remainder unit under a small sequencer.
// ----------------------------------------------------------------------------
module trial_division_prime_test #(
    parameter int DATA_WIDTH = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  wire  [DATA_WIDTH-1:0]  i_value,
    output logic                   o_valid,
    input  wire                    i_stall,
    output logic                   o_is_prime
);

    localparam int SW = 2 * DATA_WIDTH;

    tdpt_pkg::t_state      r_state, n_state;
    tdpt_pkg::t_phase      r_phase, n_phase;
    logic [DATA_WIDTH-1:0] r_n, n_n;
    logic [DATA_WIDTH-1:0] r_i, n_i;
    logic [SW-1:0]         r_sq, n_sq;
    logic                  r_verdict, n_verdict;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_prime, n_out_prime;

    logic                  w_accept;
    logic                  w_mod_start;
    logic [DATA_WIDTH-1:0] w_divisor;
    logic [SW-1:0]         w_i_wide;
    tdpt_pkg::t_mod_status w_mod_st;

    assign o_stall  = (r_state != tdpt_pkg::ST_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_i_wide = SW'(r_i);

    always_comb begin
        case (r_phase)
            tdpt_pkg::PH_TWO:   w_divisor = DATA_WIDTH'(tdpt_pkg::DIV_TWO);
            tdpt_pkg::PH_THREE: w_divisor = DATA_WIDTH'(tdpt_pkg::DIV_THREE);
            tdpt_pkg::PH_LOW:   w_divisor = r_i;
            tdpt_pkg::PH_HIGH:  w_divisor = r_i + DATA_WIDTH'(tdpt_pkg::DIV_PAIR_GAP);
            default:            w_divisor = r_i;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_n         = r_n;
        n_i         = r_i;
        n_sq        = r_sq;
        n_verdict   = r_verdict;
        n_out_valid = r_out_valid;
        n_out_prime = r_out_prime;
        w_mod_start = 1'b0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            tdpt_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_n     = i_value;
                    n_phase = tdpt_pkg::PH_TWO;
                    n_i     = DATA_WIDTH'(tdpt_pkg::DIV_FIRST);
                    n_sq    = SW'(tdpt_pkg::SQ_FIRST);
                    if (i_value[DATA_WIDTH-1] ||
                        i_value <= DATA_WIDTH'(tdpt_pkg::ONE)) begin
                        n_verdict = 1'b0;
                        n_state   = tdpt_pkg::ST_FINISH;
                    end else if (i_value <= DATA_WIDTH'(tdpt_pkg::DIV_THREE)) begin
                        n_verdict = 1'b1;
                        n_state   = tdpt_pkg::ST_FINISH;
                    end else begin
                        n_state = tdpt_pkg::ST_NEXT;
                    end
                end
            end
            tdpt_pkg::ST_NEXT: begin
                // pair loop ends once i*i passes the value
                if (r_phase == tdpt_pkg::PH_LOW && r_sq > SW'(r_n)) begin
                    n_verdict = 1'b1;
                    n_state   = tdpt_pkg::ST_FINISH;
                end else begin
                    w_mod_start = 1'b1;
                    n_state     = tdpt_pkg::ST_DIV;
                end
            end
            tdpt_pkg::ST_DIV: begin
                if (w_mod_st.done) begin
                    if (w_mod_st.zero) begin
                        n_verdict = 1'b0;
                        n_state   = tdpt_pkg::ST_FINISH;
                    end else begin
                        n_state = tdpt_pkg::ST_NEXT;
                        case (r_phase)
                            tdpt_pkg::PH_TWO:   n_phase = tdpt_pkg::PH_THREE;
                            tdpt_pkg::PH_THREE: n_phase = tdpt_pkg::PH_LOW;
                            tdpt_pkg::PH_LOW:   n_phase = tdpt_pkg::PH_HIGH;
                            tdpt_pkg::PH_HIGH: begin
                                // advance to the next pair, square kept by 12*i + 36
                                n_phase = tdpt_pkg::PH_LOW;
                                n_i     = r_i + DATA_WIDTH'(tdpt_pkg::DIV_STEP);
                                n_sq    = r_sq + (w_i_wide << 3) + (w_i_wide << 2)
                                          + SW'(tdpt_pkg::SQ_STEP_ADD);
                            end
                            default:            n_phase = tdpt_pkg::PH_LOW;
                        endcase
                    end
                end
            end
            tdpt_pkg::ST_FINISH: begin
                // hold until the output register is free
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out_prime = r_verdict;
                    n_state     = tdpt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tdpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tdpt_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase     <= n_phase;
        r_n         <= n_n;
        r_i         <= n_i;
        r_sq        <= n_sq;
        r_verdict   <= n_verdict;
        r_out_prime <= n_out_prime;
    end

    tdpt_mod_unit #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_mod_start),
        .i_dividend (r_n),
        .i_divisor  (w_divisor),
        .o_status   (w_mod_st)
    );

    assign o_valid    = r_out_valid;
    assign o_is_prime = r_out_prime;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != tdpt_pkg::ST_IDLE))
        else $error("accepted item did not start the sequencer");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_st.done |-> (r_state == tdpt_pkg::ST_DIV))
        else $error("remainder unit finished outside the divide state");

    a_prime_not_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_valid) && o_is_prime) |->
            (r_n[0] || r_n == DATA_WIDTH'(tdpt_pkg::DIV_TWO)))
        else $error("even value other than two reported prime");

endmodule
`default_nettype wire

// ===== bench/trial_division_prime_test_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// trial_division_prime_test_test
// Drives signed values into the primality tester under random idling on both
// handshakes and checks each is_prime result against a local predictor.
// ----------------------------------------------------------------------------
module trial_division_prime_test_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_WIDTH  = 32;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int IDLE_PCT    = 37;
    // Items in this window run with no idling on either side
    localparam int QUIET_FIRST = 40;
    localparam int QUIET_LAST  = 65;
    localparam int RANDOM_ITEMS = 77;

    typedef logic [DATA_WIDTH-1:0] t_value;

    typedef struct {
        t_value value;
        logic   is_prime;
    } t_primality;

    logic   i_clk;
    logic   i_rst_n  = 1'b0;
    logic   i_valid  = 1'b0;
    t_value i_value  = '0;
    logic   i_stall  = 1'b0;
    logic   o_stall;
    logic   o_valid;
    logic   o_is_prime;

    t_value     pending_values[$];
    t_primality expected_primality[$];
    int         items_driven   = 0;
    int         results_seen   = 0;
    int         mismatch_count = 0;
    int         cycle_count    = 0;

    trial_division_prime_test #(
        .DATA_WIDTH (DATA_WIDTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_is_prime (o_is_prime)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Trial division over 6k-1 / 6k+1 pairs, at 64 bits so the bound never wraps
    function automatic logic predict_prime(t_value v);
        longint unsigned n;
        longint unsigned d;
        if (v[DATA_WIDTH-1])
            return 1'b0;
        n = longint'(v);
        if (n <= 1)
            return 1'b0;
        if (n <= 3)
            return 1'b1;
        if (n % 2 == 0 || n % 3 == 0)
            return 1'b0;
        for (d = 5; d * d <= n; d += 6) begin
            if (n % d == 0 || n % (d + 2) == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int idle_pct(int count);
        return (count >= QUIET_FIRST && count <= QUIET_LAST) ? 0 : IDLE_PCT;
    endfunction

    // Keep most items cheap; large magnitudes only where a small factor or the sign ends the search
    function automatic t_value random_value();
        int unsigned pick;
        int unsigned a;
        int unsigned b;
        pick = $urandom_range(99);
        if (pick < 45) begin
            return t_value'($urandom_range(4095));
        end else if (pick < 60) begin
            a = $urandom_range(127) * 2 + 3;
            b = $urandom_range(127) * 2 + 3;
            return t_value'(a * b);
        end else if (pick < 70) begin
            return t_value'($urandom_range(1 << 20) | 1);
        end else if (pick < 78) begin
            return t_value'($urandom() & 32'hFFFF_FFFE);
        end else if (pick < 84) begin
            a = $urandom_range(715827882);
            return t_value'(a * 3);
        end else if (pick < 90) begin
            a = $urandom_range(1, 429496729);
            return t_value'(a * 5);
        end else begin
            return t_value'($urandom() | 32'h8000_0000);
        end
    endfunction

    initial begin
        pending_values = '{
            32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd2, 32'd3, 32'd4,
            32'd5, 32'd7, 32'd9, 32'd25, 32'd35, 32'd49, 32'd77, 32'd121,
            32'd143, 32'd169, 32'd289, 32'd323, 32'd65537,
            32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h7FFF_FFFD
        };
        for (int k = 0; k < RANDOM_ITEMS; k++)
            pending_values.insert(pending_values.size(), random_value());

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every item is accepted and every result is back
        @(negedge i_clk);
        while (pending_values.size() != 0 || i_valid || expected_primality.size() != 0)
            @(negedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Present the next item once the current one is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (pending_values.size() != 0 && $urandom_range(99) >= idle_pct(items_driven)) begin
                i_valid <= 1'b1;
                i_value <= pending_values.pop_front();
                items_driven++;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < idle_pct(results_seen));
        end
    end

    // Check results first, then record the item accepted at this edge
    always @(posedge i_clk) begin
        t_primality want;
        t_primality got;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen <= results_seen + 1;
                if (expected_primality.size() == 0) begin
                    $display("%0t: unexpected result: expected none, actual is_prime %0b",
                             $time, o_is_prime);
                    mismatch_count++;
                end else begin
                    want = expected_primality.pop_front();
                    if (o_is_prime !== want.is_prime) begin
                        $display("%0t: is_prime for value %0d: expected %0b, actual %0b",
                                 $time, $signed(want.value), want.is_prime, o_is_prime);
                        mismatch_count++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                got.value    = i_value;
                got.is_prime = predict_prime(i_value);
                expected_primality.insert(expected_primality.size(), got);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, expected_primality.size());
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
`default_nettype wire

// ===== files.f =====
src/tdpt_pkg.sv
src/tdpt_mod_unit.sv
src/trial_division_prime_test.sv
bench/trial_division_prime_test_test.sv
